// ----- src/tlw_pkg.sv -----
package tlw_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_PHASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_ON_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_OFF_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_BLINKS     = 3'd5;

  // Lamp codes: bit0 green A, bit1 yellow A, bit2 red A, bit3 red B,
  // bit4 yellow B, bit5 green B
  localparam logic [5:0] LAMPS_DARK    = 6'h00;
  localparam logic [5:0] LAMPS_ALL_RED = 6'h0C;
  localparam logic [5:0] LAMPS_A_GREEN  = 6'h09;
  localparam logic [5:0] LAMPS_A_YELLOW = 6'h0A;
  localparam logic [5:0] LAMPS_B_GREEN  = 6'h24;
  localparam logic [5:0] LAMPS_B_YELLOW = 6'h14;

  typedef struct packed {
    logic [7:0] steps_per_phase;
    logic [7:0] ticks_per_step;
    logic [7:0] blank_ticks;
    logic [7:0] walk_on_ticks;
    logic [7:0] walk_off_ticks;
    logic [3:0] walk_blinks;
  } cfg_regs_t;

  function automatic logic [5:0] pattern_lamps(input logic [1:0] pat);
    logic [5:0] lamps;
    case (pat)
      2'd0:    lamps = LAMPS_A_GREEN;
      2'd1:    lamps = LAMPS_A_YELLOW;
      2'd2:    lamps = LAMPS_B_GREEN;
      default: lamps = LAMPS_B_YELLOW;
    endcase
    return lamps;
  endfunction

endpackage

// ----- src/tlw_cfg_regs.sv -----
module tlw_cfg_regs import tlw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.steps_per_phase <= 8'd9;
      regs_r.ticks_per_step  <= 8'd3;
      regs_r.blank_ticks     <= 8'd5;
      regs_r.walk_on_ticks   <= 8'd10;
      regs_r.walk_off_ticks  <= 8'd5;
      regs_r.walk_blinks     <= 4'd5;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STEPS_PER_PHASE: regs_r.steps_per_phase <= wr_data;
        REG_TICKS_PER_STEP:  regs_r.ticks_per_step  <= wr_data;
        REG_BLANK_TICKS:     regs_r.blank_ticks     <= wr_data;
        REG_WALK_ON_TICKS:   regs_r.walk_on_ticks   <= wr_data;
        REG_WALK_OFF_TICKS:  regs_r.walk_off_ticks  <= wr_data;
        REG_WALK_BLINKS:     regs_r.walk_blinks     <= wr_data[3:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ----- src/traffic_light_with_walk_request.sv -----
// An accepted input transfer has its result in the output register in the next cycle.
// Throughput: one tick per cycle while out_ready allows; the whole update for a tick is
//   one pass of counter/compare logic between the state and output registers.
// The output register frees up in the same cycle it is taken, so ticks stream.
// Reset (rst_n low, synchronous): road A green pattern, all counters zero,
//   no request pending, registers back to their defaults, output empty.
module traffic_light_with_walk_request import tlw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // tick channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_button_pressed,
  // lamp channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_road_lamps,
  output logic                  out_walk_lamp,
  output logic                  out_dont_walk_lamp,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Controller modes. Codes 0..3 are the vehicle patterns so the low two
  // bits index the lamp table directly.
  typedef enum logic [2:0] {
    M_A_GREEN   = 3'd0,
    M_A_YELLOW  = 3'd1,
    M_B_GREEN   = 3'd2,
    M_B_YELLOW  = 3'd3,
    M_DARK      = 3'd4,
    M_WALK_ON   = 3'd5,
    M_WALK_OFF  = 3'd6
  } mode_t;

  cfg_regs_t cfg;

  // Config writes land out of reset; the user must write only while idle (unchecked).
  assign cfg_ready = rst_n;

  tlw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  mode_t       mode_r,  mode_nxt;
  logic [7:0]  step_r,  step_nxt;
  logic [7:0]  tick_r,  tick_nxt;
  logic        req_r,   req_nxt;
  logic        tog_r,   tog_nxt;
  logic [3:0]  blink_r, blink_nxt;
  logic        resume_r, resume_nxt;

  logic        out_valid_r;
  logic [5:0]  lamps_r,  lamps_nxt;
  logic        walk_r,   walk_nxt;
  logic        dwalk_r,  dwalk_nxt;

  logic        accept;
  logic [7:0]  dur;
  logic [7:0]  tick_inc;
  logic        tick_done;
  logic [7:0]  step_inc;
  logic [3:0]  blink_inc;

  // Result register drains in the cycle it is taken, so a new tick can
  // land while the previous result goes out. No tick is taken in reset.
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // One shared tick counter; its period depends on the mode.
  always_comb begin
    case (mode_r)
      M_DARK:     dur = cfg.blank_ticks;
      M_WALK_ON:  dur = cfg.walk_on_ticks;
      M_WALK_OFF: dur = cfg.walk_off_ticks;
      default:    dur = cfg.ticks_per_step;
    endcase
  end

  // Increment first, then compare: a zero duration behaves as one.
  assign tick_inc  = tick_r + 8'd1;
  assign tick_done = (tick_inc >= dur);
  assign step_inc  = step_r + 8'd1;
  assign blink_inc = blink_r + 4'd1;

  always_comb begin
    mode_nxt   = mode_r;
    step_nxt   = step_r;
    tick_nxt   = tick_done ? 8'd0 : tick_inc;
    req_nxt    = req_r;
    tog_nxt    = tog_r;
    blink_nxt  = blink_r;
    resume_nxt = resume_r;
    lamps_nxt  = LAMPS_DARK;
    walk_nxt   = 1'b0;
    dwalk_nxt  = 1'b0;

    unique case (mode_r)
      M_A_GREEN, M_A_YELLOW, M_B_GREEN, M_B_YELLOW: begin
        lamps_nxt = pattern_lamps(mode_r[1:0]);
        dwalk_nxt = tog_r;
        // press latched on any vehicle tick
        if (in_button_pressed) req_nxt = 1'b1;
        if (tick_done) begin
          tog_nxt  = !tog_r;
          step_nxt = step_inc;
          if (step_inc >= cfg.steps_per_phase) begin
            step_nxt = 8'd0;
            // walk sequence may only follow a yellow pattern
            if ((mode_r == M_A_YELLOW || mode_r == M_B_YELLOW) && req_nxt) begin
              resume_nxt = (mode_r == M_A_YELLOW);
              mode_nxt   = M_DARK;
            end else begin
              mode_nxt = mode_t'({1'b0, mode_r[1:0] + 2'd1});
            end
          end
        end
      end
      M_DARK: begin
        if (tick_done) begin
          blink_nxt = 4'd0;
          mode_nxt  = M_WALK_ON;
        end
      end
      M_WALK_ON: begin
        lamps_nxt = LAMPS_ALL_RED;
        walk_nxt  = 1'b1;
        if (tick_done) mode_nxt = M_WALK_OFF;
      end
      M_WALK_OFF: begin
        lamps_nxt = LAMPS_ALL_RED;
        if (tick_done) begin
          blink_nxt = blink_inc;
          if (blink_inc >= cfg.walk_blinks) begin
            blink_nxt = 4'd0;
            req_nxt   = 1'b0;
            mode_nxt  = resume_r ? M_B_GREEN : M_A_GREEN;
          end else begin
            mode_nxt = M_WALK_ON;
          end
        end
      end
      default: begin
        // unused code: dark output, restart at road A green
        mode_nxt = M_A_GREEN;
        tick_nxt = 8'd0;
        step_nxt = 8'd0;
      end
    endcase
  end

  // State advances only on an accepted tick; result register loads with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_A_GREEN;
      step_r      <= 8'd0;
      tick_r      <= 8'd0;
      req_r       <= 1'b0;
      tog_r       <= 1'b0;
      blink_r     <= 4'd0;
      resume_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        step_r   <= step_nxt;
        tick_r   <= tick_nxt;
        req_r    <= req_nxt;
        tog_r    <= tog_nxt;
        blink_r  <= blink_nxt;
        resume_r <= resume_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      lamps_r <= lamps_nxt;
      walk_r  <= walk_nxt;
      dwalk_r <= dwalk_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_road_lamps     = lamps_r;
  assign out_walk_lamp      = walk_r;
  assign out_dont_walk_lamp = dwalk_r;

  // A request stays pending through the whole dark and walk sequence.
  a_req_held_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_DARK || mode_r == M_WALK_ON || mode_r == M_WALK_OFF) |-> req_r)
    else $error("walk sequence running without a pending request");

  // Every accepted tick leaves a result behind.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted tick produced no result");

  // Walk lamp only ever lights with all roads red.
  a_walk_all_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && walk_r) |-> (lamps_r == LAMPS_ALL_RED))
    else $error("walk lamp lit while a road is not red");

  // Don't-walk lamp is dark outside the vehicle patterns.
  a_dwalk_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (lamps_r == LAMPS_ALL_RED || lamps_r == LAMPS_DARK)) |-> !dwalk_r)
    else $error("don't-walk lamp lit during dark or walk phase");

endmodule
